### rtl/circle_box_collision_side_macros.svh
// ---------------------------------------------------------------------------
// Circle/box side test assertion macros
// Shared concurrent assertion shorthands for the RTL of this block.
// ---------------------------------------------------------------------------
`ifndef CIRCLE_BOX_COLLISION_SIDE_MACROS_SVH
`define CIRCLE_BOX_COLLISION_SIDE_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define CBC_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define CBC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/cbc_pkg.sv
// ---------------------------------------------------------------------------
// Circle/box side test package
// Side codes and fixed output widths shared by the block's modules.
// ---------------------------------------------------------------------------
package cbc_pkg;

  localparam int unsigned SIDE_BITS   = 3;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [SIDE_BITS-1:0] {
    SIDE_NONE   = 3'd0,
    SIDE_LEFT   = 3'd1,
    SIDE_RIGHT  = 3'd2,
    SIDE_BOTTOM = 3'd3,
    SIDE_TOP    = 3'd4
  } side_e;

endpackage

### rtl/cbc_side.sv
// ---------------------------------------------------------------------------
// Circle/box side evaluator
// Clamp, distance test and side choice for one circle/box pair.
// ---------------------------------------------------------------------------
module cbc_side #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic        [COORD_BITS-2:0] radius_i,
  input  logic signed [COORD_BITS-1:0] box_x_i,
  input  logic signed [COORD_BITS-1:0] box_y_i,
  input  logic        [COORD_BITS-2:0] box_width_i,
  input  logic        [COORD_BITS-2:0] box_height_i,
  output cbc_pkg::side_e               hit_side_o
);
  import cbc_pkg::*;

  localparam int unsigned W  = COORD_BITS + 3;
  localparam int unsigned LW = COORD_BITS - 1;
  localparam int unsigned SW = 2 * LW;

  logic signed [W-1:0] cx, cy, r, left, bottom, right, top;
  logic signed [W-1:0] nx, ny, dx_s, dy_s, dx, dy;
  logic signed [W-1:0] pl, pr, pb, pt;
  logic        [LW-1:0] dx_n, dy_n;
  logic        [SW-1:0] dx2, dy2, r2;
  logic        [SW:0]   d2;
  logic                 near, hit;
  logic                 on_l, on_r, on_b, on_t;

  assign cx     = $signed({{3{center_x_i[COORD_BITS-1]}}, center_x_i});
  assign cy     = $signed({{3{center_y_i[COORD_BITS-1]}}, center_y_i});
  assign left   = $signed({{3{box_x_i[COORD_BITS-1]}}, box_x_i});
  assign bottom = $signed({{3{box_y_i[COORD_BITS-1]}}, box_y_i});
  assign r      = $signed({4'b0, radius_i});
  // Far edges are formed wide so they never wrap.
  assign right  = left + $signed({4'b0, box_width_i});
  assign top    = bottom + $signed({4'b0, box_height_i});

  // Nearest box point.
  assign nx = (cx < left) ? left : ((cx > right) ? right : cx);
  assign ny = (cy < bottom) ? bottom : ((cy > top) ? top : cy);

  assign dx_s = cx - nx;
  assign dy_s = cy - ny;
  assign dx   = dx_s[W-1] ? -dx_s : dx_s;
  assign dy   = dy_s[W-1] ? -dy_s : dy_s;

  // Below the radius each distance fits the length width, so squares stay exact.
  assign near = (dx < r) && (dy < r);
  assign dx_n = dx[LW-1:0];
  assign dy_n = dy[LW-1:0];
  assign dx2  = dx_n * dx_n;
  assign dy2  = dy_n * dy_n;
  assign r2   = radius_i * radius_i;
  assign d2   = {1'b0, dx2} + {1'b0, dy2};
  assign hit  = near && (d2 < {1'b0, r2});

  assign on_l = (nx == left);
  assign on_r = (nx == right);
  assign on_b = (ny == bottom);
  assign on_t = (ny == top);

  assign pl = cx + r - left;
  assign pr = right - cx + r;
  assign pb = cy + r - bottom;
  assign pt = top - cy + r;

  always_comb begin
    logic signed [W-1:0] best;
    side_e               side;
    best = pr;
    side = SIDE_NONE;
    if (hit) begin
      if ((on_l || on_r) && (on_b || on_t)) begin
        // Corner: start from the vertical edge, keep the least penetration.
        if (on_l) begin
          best = pl;
          side = SIDE_LEFT;
          if (on_r && (pr < best)) begin
            best = pr;
            side = SIDE_RIGHT;
          end
        end else begin
          best = pr;
          side = SIDE_RIGHT;
        end
        if (on_b && (pb < best)) begin
          best = pb;
          side = SIDE_BOTTOM;
        end
        if (on_t && (pt < best)) begin
          side = SIDE_TOP;
        end
      end else if (on_l) begin
        side = SIDE_LEFT;
      end else if (on_r) begin
        side = SIDE_RIGHT;
      end else if (on_b) begin
        side = SIDE_BOTTOM;
      end else if (on_t) begin
        side = SIDE_TOP;
      end
    end
    hit_side_o = side;
  end

endmodule

### rtl/circle_box_collision_side.sv
// ---------------------------------------------------------------------------
// Circle/box side test
// Streaming top level: input register, side evaluator, result register.
// ---------------------------------------------------------------------------
// Takes one circle (center, radius) and one axis-aligned box (left/bottom
// corner, width, height) per transfer, all in Q12.4 fixed point, and returns
// which box side the circle hits: 0 none, 1 left, 2 right, 3 bottom, 4 top.
// The center is clamped into the box; a hit needs the squared distance to the
// clamped point below the squared radius and that point on a box edge, so a
// center strictly inside the box reports none. At a corner the touched edge
// with the least penetration wins, left considered first, then right, bottom
// and top, each replacing the pick only when strictly smaller. The block takes
// one item every cycle unless the master side stalls. The input transfer
// loads the input register, and the result register loads from it through
// a single combinational pass of the side evaluator when it advances.
// Both registers advance together whenever the result register is empty or
// being drained, so a stall on the master side holds the pipe and
// back-pressures the slave side.
// ---------------------------------------------------------------------------
module circle_box_collision_side #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  // center_x, center_y, radius, box_x, box_y, box_width, box_height, zero pad
  input  logic [((7*COORD_BITS-3+7)/8)*8-1:0]        s_axis_tdata_i,
  output logic                                       m_axis_tvalid_o,
  input  logic                                       m_axis_tready_i,
  // hit_side, zero pad
  output logic [cbc_pkg::OUT_TDATA_W-1:0]            m_axis_tdata_o
);
  import cbc_pkg::*;

  `include "circle_box_collision_side_macros.svh"

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned IN_BITS = 7 * C - 3;
  // Field offsets in tdata, lowest field first.
  localparam int unsigned CX_LO = 0;
  localparam int unsigned CY_LO = CX_LO + C;
  localparam int unsigned R_LO  = CY_LO + C;
  localparam int unsigned BX_LO = R_LO + C - 1;
  localparam int unsigned BY_LO = BX_LO + C;
  localparam int unsigned BW_LO = BY_LO + C;
  localparam int unsigned BH_LO = BW_LO + C - 1;

  logic               in_vld_q, in_vld_d;
  logic [IN_BITS-1:0] in_data_q;
  logic               out_vld_q, out_vld_d;
  side_e              side_q;
  side_e              side_d;
  logic               adv_out, adv_in;

  // Advance the result stage when it is empty or its transfer completes;
  // advance the input stage when it is empty or can hand over.
  assign adv_out = !out_vld_q || m_axis_tready_i;
  assign adv_in  = !in_vld_q || adv_out;

  assign s_axis_tready_o = adv_in;
  assign in_vld_d        = adv_in ? s_axis_tvalid_i : in_vld_q;
  assign out_vld_d       = adv_out ? in_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers: capture on advance only, no reset needed.
  always_ff @(posedge clk_i) begin
    if (adv_in) begin
      in_data_q <= s_axis_tdata_i[IN_BITS-1:0];
    end
    if (adv_out) begin
      side_q <= side_d;
    end
  end

  cbc_side #(
    .COORD_BITS(C)
  ) u_side (
    .center_x_i  ($signed(in_data_q[CX_LO +: C])),
    .center_y_i  ($signed(in_data_q[CY_LO +: C])),
    .radius_i    (in_data_q[R_LO +: C-1]),
    .box_x_i     ($signed(in_data_q[BX_LO +: C])),
    .box_y_i     ($signed(in_data_q[BY_LO +: C])),
    .box_width_i (in_data_q[BW_LO +: C-1]),
    .box_height_i(in_data_q[BH_LO +: C-1]),
    .hit_side_o  (side_d)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - SIDE_BITS)'(0), side_q};

  // An accepted item always lands in the input stage.
  `CBC_ASSERT_NEXT(a_in_load, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, in_vld_q, "accepted item lost at input stage")
  // A held input item is not dropped while the result stage stalls.
  `CBC_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_vld_q && !adv_out, in_vld_q, "input stage dropped item under stall")
  // Handing over the input stage fills the result stage.
  `CBC_ASSERT_NEXT(a_out_load, clk_i, rst_ni, in_vld_q && adv_out, out_vld_q, "result stage missed hand-over")
  // A zero radius never hits.
  `CBC_ASSERT_NEXT(a_zero_r, clk_i, rst_ni, in_vld_q && adv_out && (in_data_q[R_LO +: C-1] == '0), side_q == SIDE_NONE, "zero radius reported a hit")
  // Input is never refused while the result register drains.
  `CBC_ASSERT_NOW(a_ready, clk_i, rst_ni, m_axis_tready_i, s_axis_tready_o, "input stalled with output draining")

endmodule

### tb/hit_side_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Circle/box hit side checker
// Watches both stream channels of the side test, predicts the hit side of
// every input transfer and compares each result transfer against the oldest
// prediction still waiting.
// ---------------------------------------------------------------------------
module hit_side_checker #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned IN_W       = ((7*COORD_BITS-3+7)/8)*8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [IN_W-1:0]                 in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [cbc_pkg::OUT_TDATA_W-1:0] out_data_i,
  output int                              mismatch_count_o,
  output int                              sides_outstanding_o
);
  import cbc_pkg::*;

  localparam int unsigned C = COORD_BITS;
  localparam int MAX_LINES  = 100;

  typedef struct {
    logic [IN_W-1:0] item;
    side_e           side;
  } side_entry_t;

  side_entry_t expected_sides_q[$];
  side_entry_t oldest;
  int          mismatch_count    = 0;
  int          sides_outstanding = 0;

  assign mismatch_count_o    = mismatch_count;
  assign sides_outstanding_o = sides_outstanding;

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_LINES)
      $display("%0t ns hit_side_checker: %s", $time, what);
    mismatch_count++;
  endtask

  // Exact integer evaluation at 64 bits: far edges never wrap, squares fit.
  function automatic side_e predict_hit_side(input logic [IN_W-1:0] item);
    longint cx, cy, rad, wid, hgt, lft, bot, rgt, tp;
    longint nx, ny, dx, dy, pl, pr, pb, pt, best;
    bit     on_l, on_r, on_b, on_t;
    side_e  side;
    cx  = longint'($signed(item[0 +: C]));
    cy  = longint'($signed(item[C +: C]));
    rad = longint'(item[2*C +: C-1]);
    lft = longint'($signed(item[3*C-1 +: C]));
    bot = longint'($signed(item[4*C-1 +: C]));
    wid = longint'(item[5*C-1 +: C-1]);
    hgt = longint'(item[6*C-2 +: C-1]);
    rgt = lft + wid;
    tp  = bot + hgt;
    nx  = (cx < lft) ? lft : ((cx > rgt) ? rgt : cx);
    ny  = (cy < bot) ? bot : ((cy > tp) ? tp : cy);
    dx  = (cx > nx) ? cx - nx : nx - cx;
    dy  = (cy > ny) ? cy - ny : ny - cy;
    side = SIDE_NONE;
    if (dx < rad && dy < rad && dx*dx + dy*dy < rad*rad) begin
      on_l = (nx == lft);
      on_r = (nx == rgt);
      on_b = (ny == bot);
      on_t = (ny == tp);
      if ((on_l || on_r) && (on_b || on_t)) begin
        // Corner: least penetration wins, an earlier edge keeps a tie.
        pl = cx + rad - lft;
        pr = rgt - (cx - rad);
        pb = cy + rad - bot;
        pt = tp - (cy - rad);
        if (on_l) begin
          best = pl;
          side = SIDE_LEFT;
          if (on_r && pr < best) begin
            best = pr;
            side = SIDE_RIGHT;
          end
        end else begin
          best = pr;
          side = SIDE_RIGHT;
        end
        if (on_b && pb < best) begin
          best = pb;
          side = SIDE_BOTTOM;
        end
        if (on_t && pt < best)
          side = SIDE_TOP;
      end else if (on_l) begin
        side = SIDE_LEFT;
      end else if (on_r) begin
        side = SIDE_RIGHT;
      end else if (on_b) begin
        side = SIDE_BOTTOM;
      end else if (on_t) begin
        side = SIDE_TOP;
      end
    end
    return side;
  endfunction

  // Check the result transfer before queuing this edge's input transfer: a
  // result can never belong to an item accepted at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_sides_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no item waiting", out_data_i));
        end else begin
          oldest = expected_sides_q.pop_front();
          if (out_data_i[SIDE_BITS-1:0] !== oldest.side)
            report_mismatch($sformatf("hit_side %0d, predicted %s, item %h",
                                      out_data_i[SIDE_BITS-1:0], oldest.side.name(),
                                      oldest.item));
          if (out_data_i[OUT_TDATA_W-1:SIDE_BITS] !== '0)
            report_mismatch($sformatf("tdata padding %h not zero, item %h",
                                      out_data_i, oldest.item));
        end
      end
      if (in_valid_i && in_ready_i)
        expected_sides_q.push_back('{item: in_data_i, side: predict_hit_side(in_data_i)});
      sides_outstanding = expected_sides_q.size();
    end
  end

endmodule

### tb/circle_box_collision_side_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Circle/box side test bench
// Drives circle/box pairs into the side test over its input stream, first a
// directed set of edge, corner and extreme cases and then random pairs mostly
// placed around the box, with random gaps and stalls on both streams. The
// checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module circle_box_collision_side_tb;

  import cbc_pkg::*;

  localparam int unsigned C            = 16;
  localparam int unsigned IN_W         = ((7*C-3+7)/8)*8;
  localparam int          RANDOM_ITEMS = 1830;
  localparam int          BACKLOG_AT   = 500;   // transfers before the long output stall
  localparam int          BACKLOG_LEN  = 300;   // cycles of that stall
  localparam int          DRAIN_AT     = 900;   // random item where the sender drains
  localparam int          TAIL_CYCLES  = 8;     // idle tail after the drain wait
  localparam int          DRAIN_LIMIT  = 20000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // center_x, center_y, radius, box_x, box_y, box_width, box_height, zero pad
  logic [IN_W-1:0]        s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // hit_side, zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int mismatches;
  int sides_outstanding;
  int items_sent = 0;
  bit sender_burst   = 1'b0;
  bit receiver_burst = 1'b0;

  always #2 clk_i = ~clk_i;

  circle_box_collision_side #(
    .COORD_BITS (C)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  hit_side_checker #(
    .COORD_BITS (C),
    .IN_W       (IN_W)
  ) u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (s_axis_tvalid),
    .in_ready_i          (s_axis_tready),
    .in_data_i           (s_axis_tdata),
    .out_valid_i         (m_axis_tvalid),
    .out_ready_i         (m_axis_tready),
    .out_data_i          (m_axis_tdata),
    .mismatch_count_o    (mismatches),
    .sides_outstanding_o (sides_outstanding)
  );

  // Mostly short gaps, now and then a long one; a burst flag switches
  // idling off for a stretch.
  function automatic int pick_gap(inout bit burst);
    int unsigned roll;
    if ($urandom_range(0, 149) == 0)
      burst = ~burst;
    if (burst)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    if (roll < 98) return $urandom_range(5, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [IN_W-1:0] pack_item(
    input logic [C-1:0] cx, input logic [C-1:0] cy, input logic [C-2:0] rad,
    input logic [C-1:0] bx, input logic [C-1:0] by,
    input logic [C-2:0] bw, input logic [C-2:0] bh);
    logic [IN_W-1:0] item;
    item              = '0;
    item[0 +: C]      = cx;
    item[C +: C]      = cy;
    item[2*C +: C-1]  = rad;
    item[3*C-1 +: C]  = bx;
    item[4*C-1 +: C]  = by;
    item[5*C-1 +: C-1] = bw;
    item[6*C-2 +: C-1] = bh;
    return item;
  endfunction

  // Random pair, biased toward centers near or on the box outline.
  function automatic logic [IN_W-1:0] random_item();
    int unsigned kind;
    logic [C-1:0] cx, cy, bx, by;
    logic [C-2:0] rad, bw, bh;
    kind = $urandom_range(0, 99);
    bx   = C'($urandom_range(0, 30000) - 15000);
    by   = C'($urandom_range(0, 30000) - 15000);
    bw   = (C-1)'($urandom_range(0, 256));
    bh   = (C-1)'($urandom_range(0, 256));
    rad  = (C-1)'($urandom_range(0, 128));
    cx   = C'(bx - 64 + $urandom_range(0, bw + 128));
    cy   = C'(by - 64 + $urandom_range(0, bh + 128));
    if (kind < 25) begin
      {cx, cy, bx, by} = {$urandom, $urandom};
      {rad, bw, bh}    = (3*C-3)'({$urandom, $urandom});
    end else if (kind < 65) begin
      // keep the near placement as drawn
    end else if (kind < 85) begin
      // snap onto an edge line or a corner
      case ($urandom_range(0, 2))
        0: cx = bx;
        1: cx = bx + bw;
        default: ;
      endcase
      case ($urandom_range(0, 2))
        0: cy = by;
        1: cy = by + bh;
        default: ;
      endcase
      rad = (C-1)'($urandom_range(0, 64));
    end else if (kind < 93) begin
      if ($urandom_range(0, 1)) bw = '0;
      else                      bh = '0;
      if ($urandom_range(0, 2) == 0) begin
        bw = '0;
        bh = '0;
      end
      cx = C'(bx - 24 + $urandom_range(0, 48));
      cy = C'(by - 24 + $urandom_range(0, 48));
      rad = (C-1)'($urandom_range(0, 48));
    end else begin
      bw  = (C-1)'($urandom);
      bh  = (C-1)'($urandom);
      rad = (C-1)'($urandom);
      cx  = C'($urandom);
      cy  = C'($urandom);
    end
    return pack_item(cx, cy, rad, bx, by, bw, bh);
  endfunction

  // Offer one item, hold it until the transfer, then idle for a random gap.
  task automatic send_item(input logic [IN_W-1:0] item);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
    gap = pick_gap(sender_burst);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_pair(
    input int cx, input int cy, input int rad,
    input int bx, input int by,
    input int bw, input int bh);
    send_item(pack_item(C'(cx), C'(cy), (C-1)'(rad), C'(bx), C'(by),
                        (C-1)'(bw), (C-1)'(bh)));
  endtask

  // Drop valid and wait until every predicted side has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sides_outstanding != 0) @(negedge clk_i);
  endtask

  // Output side: random stalls, plus one long hold-off while the sender keeps
  // offering, so the pipe fills and back-pressures the input.
  initial begin
    int  stall_left;
    bit  backlog_done;
    stall_left    = 0;
    backlog_done  = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (!backlog_done && items_sent >= BACKLOG_AT) begin
        backlog_done = 1'b1;
        stall_left   = BACKLOG_LEN;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = pick_gap(receiver_burst);
      end
    end
  end

  initial begin
    int waited;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part on a 10.0 x 10.0 box at the origin unless noted.
    send_pair(0, 0, 0, 0, 0, 0, 0);                  // radius zero never hits
    send_pair(80, 80, 16, 0, 0, 160, 160);           // center strictly inside
    send_pair(0, 80, 16, 0, 0, 160, 160);            // center on left edge
    send_pair(160, 80, 16, 0, 0, 160, 160);          // on right edge
    send_pair(80, 0, 16, 0, 0, 160, 160);            // on bottom edge
    send_pair(80, 160, 16, 0, 0, 160, 160);          // on top edge
    send_pair(-8, 80, 16, 0, 0, 160, 160);           // outside, left
    send_pair(168, 80, 16, 0, 0, 160, 160);          // outside, right
    send_pair(80, -8, 16, 0, 0, 160, 160);           // outside, below
    send_pair(80, 168, 16, 0, 0, 160, 160);          // outside, above
    send_pair(-8, 80, 8, 0, 0, 160, 160);            // distance equals radius
    send_pair(-12, -12, 16, 0, 0, 160, 160);         // corner just out of reach
    send_pair(-8, -4, 32, 0, 0, 160, 160);           // corner, left shallower
    send_pair(-4, -8, 32, 0, 0, 160, 160);           // corner, bottom shallower
    send_pair(-8, -8, 32, 0, 0, 160, 160);           // corner tie keeps left
    send_pair(168, 164, 32, 0, 0, 160, 160);         // corner, right shallower
    send_pair(164, 168, 32, 0, 0, 160, 160);         // corner, top shallower
    send_pair(-8, 80, 16, 0, 0, 0, 160);             // zero width, left first
    send_pair(8, 80, 16, 0, 0, 0, 160);              // zero width from the right
    send_pair(4, 4, 16, 0, 0, 0, 0);                 // point box, all edges touched
    send_pair(4, -4, 16, 0, 0, 0, 0);                // point box, ties hold right
    send_pair(-32768, -32768, 32767, 32767, 32767, 32767, 32767); // far apart
    send_pair(32767, 8, 32767, 0, 0, 32767, 16);     // right edge at the maximum
    send_pair(32767, 8, 1, 32767, 0, 32767, 16);     // widened right edge, on left
    send_pair(-1, -1, 32767, -1, -1, 32767, 32767);  // every field all ones
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == DRAIN_AT)
        drain_results();
      send_item(random_item());
    end
    s_axis_tvalid <= 1'b0;

    waited = 0;
    while (sides_outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (sides_outstanding != 0)
      $display("%0d predicted sides never came back", sides_outstanding);
    if (mismatches == 0 && sides_outstanding == 0)
      $display("circle_box_collision_side_tb: PASS");
    else
      $display("circle_box_collision_side_tb: FAIL");
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("circle_box_collision_side_tb: FAIL");
    $finish;
  end

endmodule
